[rtl/gkar_pkg.sv]
// Package for the gamepad key auto-repeat block: payload types, register
// codes, frame constants and reset values. No dependencies.
package gkar_pkg;

   localparam int KEY_BITS         = 16;
   localparam int NUM_KEYS_DEFAULT = 16;

   // frame header codes
   localparam logic [7:0] HDR_MODE_A = 8'h73;
   localparam logic [7:0] HDR_MODE_B = 8'h41;
   localparam logic [7:0] HDR_SYNC   = 8'h5A;

   // idle values
   localparam logic [15:0] STICK_IDLE = 16'h8080;
   localparam logic [15:0] KEYS_IDLE  = 16'hFFFF;
   localparam logic [7:0]  MODE_IDLE  = 8'h00;

   // register reset values
   localparam logic [23:0] PERIOD_RESET    = 24'd100000;
   localparam logic [7:0]  INIT_MULT_RESET = 8'd5;

   // register map: index is address bit 2
   localparam int         CSR_ADDR_W   = 3;
   localparam logic       REG_PERIOD   = 1'b0;
   localparam logic       REG_INIT_MUL = 1'b1;

   // per-key state word: hold multiple, press start time
   localparam int MULT_W  = 16;
   localparam int TIME_W  = 32;
   localparam int ENTRY_W = MULT_W + TIME_W;
   localparam int PROD_W  = MULT_W + 24;
   localparam logic [MULT_W-1:0] MULT_MAX = 16'hFFFF;

   typedef struct packed {
      logic        rx_valid;
      logic [7:0]  header_first;
      logic [7:0]  header_second;
      logic [15:0] key_bits;
      logic [15:0] left_stick;
      logic [15:0] right_stick;
      logic [31:0] timer_now;
   } req_type;

   typedef struct packed {
      logic [15:0] key_mask;
      logic [15:0] press_pulses;
      logic [15:0] left_out;
      logic [15:0] right_out;
      logic [7:0]  mode_out;
   } rsp_type;

   // latched frame fields that travel with an item to its result
   typedef struct packed {
      logic [15:0] key_mask;
      logic [15:0] left_out;
      logic [15:0] right_out;
      logic [7:0]  mode_out;
   } held_type;

endpackage

[rtl/gkar_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module gkar_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

[rtl/gamepad_key_autorepeat_top.sv]
// Top level of the gamepad key auto-repeat block: request sequencer, per-key
// state pipeline over gkar_ram, result queue and register port. Uses gkar_pkg.
//
// Usage: each poll is one transfer on the req_ channel (valid/ready). Every
// poll yields exactly one transfer on the rsp_ channel, in order: latched key
// mask, sticks and mode, plus the press/auto-repeat pulse mask.
// A poll with a good header walks the keys one per cycle, save where a key's
// entry is still in flight, through the per-key state memory (read, multiply,
// compare/write back), so such a poll takes one sequencer slot per key
// (NUM_KEYS, at most 16); a poll with no frame or a bad header takes one slot.
// A new poll can be taken while earlier ones are still in the pipeline: it is
// accepted as the last slot of the previous one issues.
// Results sit in a two-entry queue; at most two polls are outstanding, so a
// stalled receiver holds req_ready low once two polls are outstanding, and
// nothing is dropped. Back-to-back reads of an entry still in flight wait.
// Reset (synchronous) clears the per-key valid bits, so all keys read as
// released, loads period 100000 and initial multiple 5, and empties the queue.
// Registers: 0x0 repeat period (24 bits), 0x4 initial multiple (8 bits);
// write only while idle. pready is tied high.
module gamepad_key_autorepeat_top #(
   parameter int NUM_KEYS = gkar_pkg::NUM_KEYS_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  gkar_pkg::req_type                 req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output gkar_pkg::rsp_type                 rsp_data,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [gkar_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [31:0]                       pwdata,
   output logic [31:0]                       prdata,
   output logic                              pready
);
   import gkar_pkg::*;

   // only the keys carried by key_bits take part
   localparam int KEY_COUNT = (NUM_KEYS < KEY_BITS) ? NUM_KEYS : KEY_BITS;
   localparam int AW        = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;
   localparam logic [AW-1:0] KEY_LAST = AW'(KEY_COUNT - 1);

   // ---------------------------------------------------------------------
   // register port
   // ---------------------------------------------------------------------
   logic [23:0] period_ff;
   logic [7:0]  init_ff;
   logic        csr_wr;

   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff <= PERIOD_RESET;
         init_ff   <= INIT_MULT_RESET;
      end else if (csr_wr) begin
         case (paddr[2])
            REG_PERIOD:   period_ff <= pwdata[23:0];
            REG_INIT_MUL: init_ff   <= pwdata[7:0];
            default:      ;
         endcase
      end
   end

   always_comb begin
      case (paddr[2])
         REG_PERIOD:   prdata = {8'h00, period_ff};
         REG_INIT_MUL: prdata = {24'h000000, init_ff};
         default:      prdata = 32'h0;
      endcase
   end

   // ---------------------------------------------------------------------
   // request intake: resolve frame fields, latch the item
   // ---------------------------------------------------------------------
   logic     req_fire;
   logic     hdr_ok;
   logic     scan_new;
   held_type held_ff, held_in;

   logic        busy_ff, busy_in;
   logic [AW-1:0] idx_ff, idx_in;
   logic        item_scan_ff;
   logic [15:0] item_keys_ff;
   logic [31:0] item_now_ff;
   held_type    item_held_ff;

   logic [1:0]  outstanding_ff, outstanding_in;

   assign hdr_ok = ((req_data.header_first == HDR_MODE_A) ||
                    (req_data.header_first == HDR_MODE_B)) &&
                   (req_data.header_second == HDR_SYNC);
   assign scan_new = req_data.rx_valid && hdr_ok;

   always_comb begin
      held_in = held_ff;
      if (!req_data.rx_valid) begin
         held_in.key_mask  = KEYS_IDLE;
         held_in.left_out  = STICK_IDLE;
         held_in.right_out = STICK_IDLE;
         held_in.mode_out  = MODE_IDLE;
      end else if (hdr_ok) begin
         held_in.key_mask  = req_data.key_bits;
         held_in.left_out  = req_data.left_stick;
         held_in.right_out = req_data.right_stick;
         held_in.mode_out  = req_data.header_first;
      end
   end

   // ---------------------------------------------------------------------
   // slot issue: one slot per key for a scan, one slot otherwise
   // ---------------------------------------------------------------------
   logic          s1_vld_ff, s1_scan_ff, s1_last_ff, s1_pressed_ff;
   logic [AW-1:0] s1_addr_ff;
   logic [31:0]   s1_now_ff;
   held_type      s1_held_ff;

   logic          s2_vld_ff, s2_scan_ff, s2_last_ff, s2_pressed_ff;
   logic [AW-1:0] s2_addr_ff;
   logic [31:0]   s2_now_ff, s2_start_ff, s2_elapsed_ff;
   logic [MULT_W-1:0] s2_mult_ff;
   logic [PROD_W-1:0] s2_prod_ff;
   held_type      s2_held_ff;

   logic hazard, issue, slot_last;

   // an entry still on its way to write-back must not be read again
   assign hazard = item_scan_ff &&
                   ((s1_vld_ff && s1_scan_ff && (s1_addr_ff == idx_ff)) ||
                    (s2_vld_ff && s2_scan_ff && (s2_addr_ff == idx_ff)));
   assign issue     = busy_ff && !hazard;
   assign slot_last = !item_scan_ff || (idx_ff == KEY_LAST);

   assign req_ready = (outstanding_ff < 2'd2) && (!busy_ff || (issue && slot_last));
   assign req_fire  = req_valid && req_ready;

   always_comb begin
      busy_in = busy_ff;
      idx_in  = idx_ff;
      if (req_fire) begin
         busy_in = 1'b1;
         idx_in  = '0;
      end else if (issue) begin
         if (slot_last) begin
            busy_in = 1'b0;
         end else begin
            idx_in = idx_ff + AW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= '0;
         held_ff <= '{key_mask: KEYS_IDLE, left_out: STICK_IDLE,
                      right_out: STICK_IDLE, mode_out: MODE_IDLE};
      end else begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
         if (req_fire) begin
            held_ff <= held_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         item_scan_ff <= scan_new;
         item_keys_ff <= req_data.key_bits;
         item_now_ff  <= req_data.timer_now;
         item_held_ff <= held_in;
      end
   end

   // ---------------------------------------------------------------------
   // per-key state memory and valid bits
   // ---------------------------------------------------------------------
   logic                ram_wr;
   logic [ENTRY_W-1:0]  ram_wdata, ram_rdata;
   logic                ram_rd;
   logic [KEY_COUNT-1:0] valid_ff, valid_in;

   assign ram_rd = issue && item_scan_ff;

   gkar_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (KEY_COUNT)
   ) u_state_ram (
      .clock   (clock),
      .wr_en   (ram_wr),
      .wr_addr (s2_addr_ff),
      .wr_data (ram_wdata),
      .rd_en   (ram_rd),
      .rd_addr (idx_ff),
      .rd_data (ram_rdata)
   );

   // stage 1: read issued, carry slot info
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= issue;
      end
   end

   always_ff @(posedge clock) begin
      if (issue) begin
         s1_scan_ff    <= item_scan_ff;
         s1_last_ff    <= slot_last;
         s1_addr_ff    <= idx_ff;
         s1_pressed_ff <= !item_keys_ff[idx_ff];
         s1_now_ff     <= item_now_ff;
         s1_held_ff    <= item_held_ff;
      end
   end

   // stage 2: threshold product and elapsed time
   logic [ENTRY_W-1:0] s1_word;
   logic [MULT_W-1:0]  s1_mult;
   logic [TIME_W-1:0]  s1_start;

   assign s1_word  = valid_ff[s1_addr_ff] ? ram_rdata : '0;   // unwritten reads as zero
   assign s1_mult  = s1_word[ENTRY_W-1:TIME_W];
   assign s1_start = s1_word[TIME_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff <= 1'b0;
      end else begin
         s2_vld_ff <= s1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_vld_ff) begin
         s2_scan_ff    <= s1_scan_ff;
         s2_last_ff    <= s1_last_ff;
         s2_addr_ff    <= s1_addr_ff;
         s2_pressed_ff <= s1_pressed_ff;
         s2_now_ff     <= s1_now_ff;
         s2_held_ff    <= s1_held_ff;
         s2_mult_ff    <= s1_mult;
         s2_start_ff   <= s1_start;
         s2_elapsed_ff <= s1_now_ff - s1_start;
         s2_prod_ff    <= PROD_W'(s1_mult) * PROD_W'(period_ff);
      end
   end

   // stage 3: decide, write back, update pulse mask
   logic [MULT_W-1:0] init_eff;
   logic              pulse_bit;
   logic [15:0]       pulse_ff, pulse_in;
   logic              s2_work;

   assign init_eff = (init_ff == 8'h00) ? MULT_W'(1) : MULT_W'(init_ff);
   assign s2_work  = s2_vld_ff && s2_scan_ff;

   always_comb begin
      ram_wr    = 1'b0;
      ram_wdata = {s2_mult_ff, s2_start_ff};
      pulse_bit = 1'b0;
      valid_in  = valid_ff;
      pulse_in  = pulse_ff;
      if (s2_work) begin
         if (s2_pressed_ff) begin
            if (s2_mult_ff == '0) begin
               // first press
               ram_wr    = 1'b1;
               ram_wdata = {init_eff, s2_now_ff};
               valid_in[s2_addr_ff] = 1'b1;
               pulse_bit = 1'b1;
            end else if (PROD_W'(s2_elapsed_ff) > s2_prod_ff) begin
               // auto-repeat step, multiple saturates
               ram_wr    = 1'b1;
               ram_wdata = {(s2_mult_ff == MULT_MAX) ? s2_mult_ff : s2_mult_ff + MULT_W'(1),
                            s2_start_ff};
               pulse_bit = 1'b1;
            end
         end else begin
            valid_in[s2_addr_ff] = 1'b0;
         end
         pulse_in[s2_addr_ff] = pulse_bit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         pulse_ff <= '0;
      end else begin
         valid_ff <= valid_in;
         pulse_ff <= pulse_in;
      end
   end

   // ---------------------------------------------------------------------
   // result queue, two entries
   // ---------------------------------------------------------------------
   rsp_type     fifo_ff [2];
   logic        wr_ptr_ff, rd_ptr_ff;
   logic [1:0]  cnt_ff, cnt_in;
   logic        push, pop;
   rsp_type     push_data;

   assign push = s2_vld_ff && s2_last_ff;
   assign pop  = rsp_valid && rsp_ready;

   assign push_data = '{key_mask:     s2_held_ff.key_mask,
                        press_pulses: pulse_in,
                        left_out:     s2_held_ff.left_out,
                        right_out:    s2_held_ff.right_out,
                        mode_out:     s2_held_ff.mode_out};

   assign rsp_valid = (cnt_ff != 2'd0);
   assign rsp_data  = fifo_ff[rd_ptr_ff];

   always_comb begin
      cnt_in = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 2'd1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 2'd1;
      end
   end

   always_comb begin
      outstanding_in = outstanding_ff;
      if (req_fire && !pop) begin
         outstanding_in = outstanding_ff + 2'd1;
      end else if (pop && !req_fire) begin
         outstanding_in = outstanding_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff      <= 1'b0;
         rd_ptr_ff      <= 1'b0;
         cnt_ff         <= 2'd0;
         outstanding_ff <= 2'd0;
      end else begin
         cnt_ff         <= cnt_in;
         outstanding_ff <= outstanding_in;
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         fifo_ff[wr_ptr_ff] <= push_data;
      end
   end

`ifndef SYNTHESIS
   // credit scheme keeps the queue from overflowing
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && (cnt_ff == 2'd2)))
      else $error("result queue overflow");

   // interlock: never read an entry in the cycle it is written back
   a_no_rw_same: assert property (@(posedge clock) disable iff (reset)
      !(ram_wr && ram_rd && (s2_addr_ff == idx_ff)))
      else $error("state RAM read/write collision");

   // queued results are always covered by outstanding credits
   a_credit_cover: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= outstanding_ff)
      else $error("queued results exceed outstanding polls");

   // a released key is not held afterwards
   a_release_clears: assert property (@(posedge clock) disable iff (reset)
      (s2_work && !s2_pressed_ff) |=> !valid_ff[$past(s2_addr_ff)])
      else $error("released key still held");
`endif

endmodule
